// ----- sv/ctlex_pkg.sv -----
package ctlex_pkg;

  localparam int MAX_RES = 5;
  localparam int Q_DEPTH = 4;

  localparam logic [4:0] K_STR      = 5'd0;
  localparam logic [4:0] K_CHR      = 5'd1;
  localparam logic [4:0] K_NUM      = 5'd2;
  localparam logic [4:0] K_IDENT    = 5'd3;
  localparam logic [4:0] K_SEMI     = 5'd4;
  localparam logic [4:0] K_COND     = 5'd5;
  localparam logic [4:0] K_OPASSIGN = 5'd6;
  localparam logic [4:0] K_BINOP    = 5'd7;
  localparam logic [4:0] K_EQUALS   = 5'd8;
  localparam logic [4:0] K_LPAREN   = 5'd9;
  localparam logic [4:0] K_RPAREN   = 5'd10;
  localparam logic [4:0] K_LBRACK   = 5'd11;
  localparam logic [4:0] K_RBRACK   = 5'd12;
  localparam logic [4:0] K_LBRACE   = 5'd13;
  localparam logic [4:0] K_RBRACE   = 5'd14;
  localparam logic [4:0] K_DOT      = 5'd15;
  localparam logic [4:0] K_COLON    = 5'd16;
  localparam logic [4:0] K_COMMA    = 5'd17;
  localparam logic [4:0] K_NOT      = 5'd18;
  localparam logic [4:0] K_AMP      = 5'd19;
  localparam logic [4:0] K_TILDE    = 5'd20;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_OPENSTR = 2'd1;
  localparam logic [1:0] E_BADCHR  = 2'd2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_OP, M_LCOM, M_BCOM, M_BSTAR,
    M_STR, M_STRESC, M_CHOPEN, M_CHESC, M_CHFULL, M_CHEMPTY
  } mode_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       valid;
    logic       tend;
    logic [1:0] err;
    logic       new_line;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [2:0]         cnt;
    logic [15:0]        line_old;
    logic [15:0]        line_new;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic res_t mk_res(input logic [4:0] k, input logic [7:0] t, input logic v,
                                  input logic e, input logic [1:0] er, input logic nl);
    res_t r;
    r.kind     = k;
    r.text     = t;
    r.valid    = v;
    r.tend     = e;
    r.err      = er;
    r.new_line = nl;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'h09 && b <= CH_CR);
  endfunction

endpackage

// ----- sv/ctlex_front.sv -----
module ctlex_front #(
  parameter int LINE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          byte_value,
  input  logic                end_of_input,
  input  logic                stall,
  output logic                push,
  output ctlex_pkg::burst_t   burst
);
  import ctlex_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } kind_hit_t;

  mode_t                mode, mode_next;
  logic [7:0]           pend, pend_next;
  logic [7:0]           held, held_next;
  logic                 dot_seen, dot_seen_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic                 err_latched, err_latched_next;

  logic accept;

  function automatic logic [15:0] sat16(input logic [LINE_BITS-1:0] v);
    if ((v >> 16) != '0) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic kind_hit_t punct_kind(input logic [7:0] b);
    kind_hit_t r;
    r.hit = 1'b1;
    case (b)
      ";":     r.kind = K_SEMI;
      "(":     r.kind = K_LPAREN;
      ")":     r.kind = K_RPAREN;
      "[":     r.kind = K_LBRACK;
      "]":     r.kind = K_RBRACK;
      "{":     r.kind = K_LBRACE;
      "}":     r.kind = K_RBRACE;
      ".":     r.kind = K_DOT;
      ":":     r.kind = K_COLON;
      ",":     r.kind = K_COMMA;
      "~":     r.kind = K_TILDE;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_STR;
      end
    endcase
    return r;
  endfunction

  function automatic kind_hit_t flush_kind(input logic [7:0] p);
    kind_hit_t r;
    r.hit = 1'b1;
    case (p)
      "/", "+", "-", "*": r.kind = K_BINOP;
      "=":                r.kind = K_EQUALS;
      ">", "<":           r.kind = K_COND;
      "!":                r.kind = K_NOT;
      "&":                r.kind = K_AMP;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_STR;
      end
    endcase
    return r;
  endfunction

  assign accept = in_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      pend        <= '0;
      held        <= '0;
      dot_seen    <= 1'b0;
      line_count  <= LINE_BITS'(1);
      err_latched <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      pend        <= pend_next;
      held        <= held_next;
      dot_seen    <= dot_seen_next;
      line_count  <= line_count_next;
      err_latched <= err_latched_next;
    end
  end

  always_comb begin
    logic [7:0]         b;
    logic               lf;
    logic               bumped;
    logic               do_start;
    logic [2:0]         n;
    res_t [MAX_RES-1:0] ents;
    kind_hit_t          fk;
    kind_hit_t          pk;
    mode_t              m;

    b                = byte_value;
    lf               = (b == CH_LF);
    bumped           = 1'b0;
    do_start         = 1'b0;
    n                = '0;
    ents             = '0;
    fk               = '0;
    pk               = '0;
    m                = mode;
    pend_next        = pend;
    held_next        = held;
    dot_seen_next    = dot_seen;
    line_count_next  = line_count;
    err_latched_next = err_latched;

    if (!err_latched) begin
      case (m)
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == "_") begin
            ents[n] = mk_res(K_IDENT, b, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
          end else begin
            ents[n] = mk_res(K_IDENT, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(b) || (b == "." && !dot_seen_next)) begin
            if (b == ".") dot_seen_next = 1'b1;
            ents[n] = mk_res(K_NUM, b, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
          end else begin
            ents[n] = mk_res(K_NUM, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        M_OP: begin
          m = M_IDLE;
          if (pend == "/" && b == "/") begin
            m = M_LCOM;
          end else if (pend == "/" && b == "*") begin
            m = M_BCOM;
          end else if ((pend == "+" || pend == "-") && b == pend) begin
            ents[n] = mk_res(K_OPASSIGN, pend, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_OPASSIGN, "=", 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_OPASSIGN, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_NUM, "1", 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_NUM, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end else if (b == "=" && pend inside {"=", "!", ">", "<"}) begin
            ents[n] = mk_res(K_COND, pend, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_COND, "=", 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_COND, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end else if ((pend == "|" || pend == "&") && b == pend) begin
            ents[n] = mk_res(K_COND, pend, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_COND, pend, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_COND, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end else if (b == "=" && pend inside {"+", "-", "*", "/"}) begin
            ents[n] = mk_res(K_OPASSIGN, pend, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_OPASSIGN, "=", 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_OPASSIGN, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end else begin
            fk = flush_kind(pend);
            if (fk.hit) begin
              ents[n] = mk_res(fk.kind, pend, 1'b1, 1'b0, E_NONE, bumped);
              n = n + 3'd1;
              ents[n] = mk_res(fk.kind, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
              n = n + 3'd1;
            end
            do_start = 1'b1;
          end
        end
        M_LCOM: begin
          if (lf) begin
            if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
            bumped = 1'b1;
            m = M_IDLE;
          end
        end
        M_BCOM, M_BSTAR: begin
          if (lf) begin
            if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
            bumped = 1'b1;
          end
          if (m == M_BSTAR && b == "/") m = M_IDLE;
          else m = (b == "*") ? M_BSTAR : M_BCOM;
        end
        M_STR: begin
          if (b == "\"") begin
            ents[n] = mk_res(K_STR, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
            m = M_IDLE;
          end else if (b == "\\") begin
            m = M_STRESC;
          end else begin
            ents[n] = mk_res(K_STR, b, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            if (lf) begin
              if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
              bumped = 1'b1;
            end
          end
        end
        M_STRESC: begin
          if (b == "\"") begin
            ents[n] = mk_res(K_STR, b, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
          end else if (b == "n") begin
            ents[n] = mk_res(K_STR, CH_LF, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
          end else if (b == "r") begin
            ents[n] = mk_res(K_STR, CH_CR, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
          end
          if (lf) begin
            if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
            bumped = 1'b1;
          end
          m = M_STR;
        end
        M_CHOPEN: begin
          if (b == "\\") begin
            m = M_CHESC;
          end else begin
            held_next = b;
            if (lf) begin
              if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
              bumped = 1'b1;
            end
            m = M_CHFULL;
          end
        end
        M_CHESC: begin
          m = M_CHFULL;
          if (b == "'") held_next = b;
          else if (b == "n") held_next = CH_LF;
          else if (b == "r") held_next = CH_CR;
          else m = M_CHEMPTY;
          if (lf) begin
            if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
            bumped = 1'b1;
          end
        end
        M_CHFULL: begin
          if (b == "'") begin
            ents[n] = mk_res(K_CHR, held, 1'b1, 1'b0, E_NONE, bumped);
            n = n + 3'd1;
            ents[n] = mk_res(K_CHR, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end else begin
            ents[n] = mk_res(K_CHR, 8'h00, 1'b0, 1'b1, E_BADCHR, bumped);
            n = n + 3'd1;
            err_latched_next = 1'b1;
          end
          m = M_IDLE;
        end
        M_CHEMPTY: begin
          if (b == "'") begin
            ents[n] = mk_res(K_CHR, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end else begin
            ents[n] = mk_res(K_CHR, 8'h00, 1'b0, 1'b1, E_BADCHR, bumped);
            n = n + 3'd1;
            err_latched_next = 1'b1;
          end
          m = M_IDLE;
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        pk = punct_kind(b);
        m  = M_IDLE;
        if (is_space(b)) begin
          if (lf) begin
            if (line_count_next != '1) line_count_next = line_count_next + LINE_BITS'(1);
            bumped = 1'b1;
          end
        end else if (b inside {"/", "=", "!", ">", "<", "|", "&", "+", "-", "*"}) begin
          pend_next = b;
          m = M_OP;
        end else if (b == "\"") begin
          m = M_STR;
        end else if (b == "'") begin
          m = M_CHOPEN;
        end else if (pk.hit) begin
          ents[n] = mk_res(pk.kind, b, 1'b1, 1'b0, E_NONE, bumped);
          n = n + 3'd1;
          ents[n] = mk_res(pk.kind, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
          n = n + 3'd1;
        end else if (is_digit(b)) begin
          dot_seen_next = 1'b0;
          ents[n] = mk_res(K_NUM, b, 1'b1, 1'b0, E_NONE, bumped);
          n = n + 3'd1;
          m = M_NUM;
        end else if (is_alpha(b) || b == "_") begin
          ents[n] = mk_res(K_IDENT, b, 1'b1, 1'b0, E_NONE, bumped);
          n = n + 3'd1;
          m = M_IDENT;
        end
      end

      if (end_of_input && !err_latched_next) begin
        case (m)
          M_IDENT: begin
            ents[n] = mk_res(K_IDENT, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end
          M_NUM: begin
            ents[n] = mk_res(K_NUM, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
            n = n + 3'd1;
          end
          M_OP: begin
            fk = flush_kind(pend_next);
            if (fk.hit) begin
              ents[n] = mk_res(fk.kind, pend_next, 1'b1, 1'b0, E_NONE, bumped);
              n = n + 3'd1;
              ents[n] = mk_res(fk.kind, 8'h00, 1'b0, 1'b1, E_NONE, bumped);
              n = n + 3'd1;
            end
          end
          M_STR, M_STRESC: begin
            ents[n] = mk_res(K_STR, 8'h00, 1'b0, 1'b1, E_OPENSTR, bumped);
            n = n + 3'd1;
          end
          M_CHOPEN, M_CHESC, M_CHFULL, M_CHEMPTY: begin
            ents[n] = mk_res(K_CHR, 8'h00, 1'b0, 1'b1, E_BADCHR, bumped);
            n = n + 3'd1;
          end
          default: ;
        endcase
        m = M_IDLE;
      end
    end

    burst.ent      = ents;
    burst.cnt      = n;
    burst.line_old = sat16(line_count);
    burst.line_new = sat16(line_count_next);
    push           = accept && (n != 3'd0);

    mode_next = m;
    if (end_of_input) begin
      mode_next        = M_IDLE;
      pend_next        = '0;
      held_next        = '0;
      dot_seen_next    = 1'b0;
      line_count_next  = LINE_BITS'(1);
      err_latched_next = 1'b0;
    end
  end

endmodule

// ----- sv/ctlex_queue.sv -----
module ctlex_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ctlex_pkg::burst_t wdata,
  input  logic              pop,
  output ctlex_pkg::burst_t rdata,
  output ctlex_pkg::qstat_t stat
);
  import ctlex_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  burst_t        mem [Q_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop) rptr <= rptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign rdata      = mem[rptr];
  assign stat.full  = (count == (PW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- sv/ctlex_back.sv -----
module ctlex_back (
  input  logic              clk,
  input  logic              rst,
  input  ctlex_pkg::burst_t head,
  input  ctlex_pkg::qstat_t stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        token_kind,
  output logic [7:0]        text_byte,
  output logic              byte_valid,
  output logic              token_end,
  output logic [15:0]       line_number,
  output logic [1:0]        error_code,
  output logic              run_last
);
  import ctlex_pkg::*;

  logic [2:0] idx, idx_next;
  logic       advance;
  logic       last_ent;
  res_t       cur;

  assign advance  = !out_valid || !out_stall;
  assign cur      = head.ent[idx];
  assign last_ent = (idx == head.cnt - 3'd1);
  assign pop      = advance && !stat.empty && last_ent;

  always_comb begin
    idx_next = idx;
    if (advance && !stat.empty) idx_next = last_ent ? 3'd0 : idx + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      idx <= idx_next;
      if (advance) out_valid <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !stat.empty) begin
      token_kind  <= cur.kind;
      text_byte   <= cur.text;
      byte_valid  <= cur.valid;
      token_end   <= cur.tend;
      error_code  <= cur.err;
      line_number <= cur.new_line ? head.line_new : head.line_old;
      run_last    <= last_ent;
    end
  end

endmodule

// ----- sv/c_style_token_lexer_top.sv -----
// Streaming lexer for a small C-like language.
// Input channel: one source byte per transfer (byte_value, end_of_input),
// handshake in_valid / in_stall. Output channel: one result per transfer,
// handshake out_valid / out_stall. A token leaves as its text bytes
// (byte_valid) followed by an end marker (token_end) with kind and line;
// run_last flags the final result that one input byte caused.
// The front decodes a byte in the cycle it is taken and queues all results
// of that byte (up to five) as one burst; while out_stall is low the back
// sends one result a cycle. Results pass the queue and the output register.
// Throughput: one byte per cycle while bytes give at most one result each
// and out_stall is low; a byte with k results holds the output for all k,
// and the four-burst queue takes input until it fills, then in_stall rises.
// out_stall holds the output register; results are never dropped.
// Reset (rst, synchronous) returns the lexer to idle at line one and empties
// the queue; no clearing pass is needed. end_of_input also restores that
// state after its byte is processed.
module c_style_token_lexer_top #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [7:0]  text_byte,
  output logic        byte_valid,
  output logic        token_end,
  output logic [15:0] line_number,
  output logic [1:0]  error_code,
  output logic        run_last
);
  import ctlex_pkg::*;

  logic   push, pop;
  burst_t wburst, rburst;
  qstat_t qstat;

  assign in_stall = qstat.full;

  ctlex_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .byte_value   (byte_value),
    .end_of_input (end_of_input),
    .stall        (qstat.full),
    .push         (push),
    .burst        (wburst)
  );

  ctlex_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wburst),
    .pop   (pop),
    .rdata (rburst),
    .stat  (qstat)
  );

  ctlex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (rburst),
    .stat        (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .text_byte   (text_byte),
    .byte_valid  (byte_valid),
    .token_end   (token_end),
    .line_number (line_number),
    .error_code  (error_code),
    .run_last    (run_last)
  );

endmodule

// ----- sv/ctlex_checker.sv -----
module ctlex_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  token_kind,
  input logic [7:0]  text_byte,
  input logic        byte_valid,
  input logic        token_end,
  input logic [15:0] line_number,
  input logic [1:0]  error_code,
  input logic        run_last
);
  import ctlex_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(text_byte)
      && $stable(line_number) && $stable(run_last))
    else $error("stalled result changed");

  a_byte_or_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != token_end))
    else $error("result is neither one text byte nor one end marker");

  a_err_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != E_NONE |-> token_end && !byte_valid && run_last
      && (token_kind == K_STR || token_kind == K_CHR))
    else $error("malformed error result");

  a_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 16'd0)
    else $error("line number zero");

endmodule

bind c_style_token_lexer_top ctlex_checker u_chk (.*);
